// ===== hdl/vats_pkg.sv =====
// Package for the violin additive tone sample block: types, constants and the sine ROM builder.
`timescale 1ns / 1ps
package vats_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_FRACTION_BITS_DEF = 16;

  localparam int HARM_COUNT = 8;
  localparam int ACC_W = 35;
  localparam int PROD_W = 32;
  localparam int SAMPLE_W = 17;
  localparam int SCALE_Q16 = 32113;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int HARM_MULT [HARM_COUNT] = '{1, 2, 3, 4, 6, 7, 8, 10};
  localparam bit HARM_IS_COS [HARM_COUNT] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam int HARM_AMP [HARM_COUNT] = '{65208, 61604, 27853, 31457, 23921, 2621, 5571, 5898};

  localparam longint unsigned TAYLOR_DIV [10] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  typedef struct packed {
    logic                     valid;
    logic [PROD_W-1:0]        prod;
    logic signed [ACC_W-1:0]  acc;
  } link_t;

  // Unsigned Q0.15 sine from a Q2.30 angle, Taylor series to the 21st power
  function automatic logic [14:0] sine_from_x(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint v;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if (n[0])
        sum = sum - longint'(term);
      else
        sum = sum + longint'(term);
    end
    if (sum < 0)
      sum = 0;
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767)
      v = 64'sd32767;
    return 15'(v);
  endfunction

endpackage

// ===== hdl/violin_additive_tone_sample.sv =====
// Top level: violin additive tone sample generator, a chain of harmonic cells.
`timescale 1ns / 1ps
// Usage:
//   A transaction is taken on each rising edge with start high and busy low.
//   busy is held low: the block takes a new fundamental_freq / time_index
//   pair in every cycle.
//   The result leaves on sample with done high for exactly one cycle,
//   after the frequency-time product register, the phase and ROM lookup
//   register and the weighting and accumulation register of each of the
//   eight harmonic cells, and the 0.49 scale register and the rounded
//   output register.
//   Throughput is one sample per cycle; results come out in input order.
//   Each cell holds its own quarter-wave sine ROM and passes the product and
//   the running sum to its neighbor every cycle.
//   Synchronous reset clears every valid flag in the chain, so items in
//   flight are dropped and done stays low until new transactions arrive.
//   The receiver cannot stall: done and sample are shown for one cycle only.
module violin_additive_tone_sample #(
  parameter int SINE_TABLE_DEPTH = vats_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_FRACTION_BITS = vats_pkg::PHASE_FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [22:0]         fundamental_freq,
  input  logic [31:0]         time_index,
  output logic                done,
  output logic signed [16:0]  sample
);

  localparam int LATENCY = 3 + 2 * vats_pkg::HARM_COUNT;

  vats_pkg::link_t chain [vats_pkg::HARM_COUNT+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    chain[0].prod <= 32'(fundamental_freq) * time_index;
    chain[0].acc <= '0;
    if (rst) chain[0].valid <= 1'b0;
    else chain[0].valid <= start;
  end

  for (genvar i = 0; i < vats_pkg::HARM_COUNT; i++) begin : g_cell
    vats_cell #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
      .PHASE_FRACTION_BITS(PHASE_FRACTION_BITS),
      .MULT(vats_pkg::HARM_MULT[i]),
      .IS_COS(vats_pkg::HARM_IS_COS[i]),
      .AMP(vats_pkg::HARM_AMP[i])
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .link_in(chain[i]),
      .link_out(chain[i+1])
    );
  end

  vats_scale u_scale (
    .clk(clk),
    .rst(rst),
    .link_in(chain[vats_pkg::HARM_COUNT]),
    .done(done),
    .sample(sample)
  );

`ifndef SYNTHESIS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("transaction produced no sample");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("sample without matching transaction");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(sample) <= 17'sd55000 && $signed(sample) >= -17'sd55000))
    else $error("sample outside harmonic sum range");
`endif

endmodule

// ===== hdl/vats_cell.sv =====
// One harmonic cell: phase, quarter-wave ROM lookup, weighting and accumulation.
`timescale 1ns / 1ps
module vats_cell #(
  parameter int SINE_TABLE_DEPTH = vats_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_FRACTION_BITS = vats_pkg::PHASE_FRACTION_BITS_DEF,
  parameter int MULT = 1,
  parameter bit IS_COS = 1'b0,
  parameter int AMP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  vats_pkg::link_t link_in,
  output vats_pkg::link_t link_out
);

  localparam int PFB = PHASE_FRACTION_BITS;
  localparam int QUARTER = SINE_TABLE_DEPTH / 4;
  localparam int FULL = 4 * QUARTER;
  localparam int IDX_W = $clog2(FULL);
  localparam int OFF_W = $clog2(QUARTER + 1);
  localparam int SC_W = PFB + IDX_W + 1;
  localparam int QUARTER_PH = 1 << (PFB - 2);
  localparam logic signed [32:0] AMP_S = 33'(AMP);

  logic [14:0] rom [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    localparam longint unsigned X =
      (64'(k) * vats_pkg::HALF_PI_Q30 + 64'(QUARTER / 2)) / 64'(QUARTER);
    assign rom[k] = vats_pkg::sine_from_x(X);
  end

  logic [35:0]        hp;
  logic [PFB-1:0]     ph_sin;
  logic [PFB-1:0]     ph;
  logic [SC_W-1:0]    scaled;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   base;
  logic [IDX_W-1:0]   rel;
  logic [1:0]         quad;
  logic [OFF_W-1:0]   off_lin;
  logic [OFF_W-1:0]   off;
  logic [15:0]        mag;
  logic signed [15:0] term;

  assign hp = {4'b0, link_in.prod} * 36'(MULT);
  assign ph_sin = hp[31 -: PFB];
  assign ph = IS_COS ? ph_sin + PFB'(QUARTER_PH) : ph_sin;
  assign scaled = SC_W'(ph) * SC_W'(FULL);
  assign idx = scaled[PFB +: IDX_W];

  always_comb begin
    if (idx >= IDX_W'(3 * QUARTER)) begin
      quad = 2'd3;
      base = IDX_W'(3 * QUARTER);
    end else if (idx >= IDX_W'(2 * QUARTER)) begin
      quad = 2'd2;
      base = IDX_W'(2 * QUARTER);
    end else if (idx >= IDX_W'(QUARTER)) begin
      quad = 2'd1;
      base = IDX_W'(QUARTER);
    end else begin
      quad = 2'd0;
      base = '0;
    end
    rel = idx - base;
    off_lin = OFF_W'(rel);
    off = quad[0] ? OFF_W'(QUARTER) - off_lin : off_lin;
    mag = {1'b0, rom[off]};
    term = quad[1] ? -$signed(mag) : $signed(mag);
  end

  vats_pkg::link_t    a_link;
  logic signed [15:0] a_term;
  logic signed [32:0] weighted;

  always_ff @(posedge clk) begin
    a_link.prod <= link_in.prod;
    a_link.acc <= link_in.acc;
    a_term <= term;
    if (rst) a_link.valid <= 1'b0;
    else a_link.valid <= link_in.valid;
  end

  assign weighted = 33'(a_term) * AMP_S;

  always_ff @(posedge clk) begin
    link_out.prod <= a_link.prod;
    link_out.acc <= a_link.acc + vats_pkg::ACC_W'(weighted);
    if (rst) link_out.valid <= 1'b0;
    else link_out.valid <= a_link.valid;
  end

endmodule

// ===== hdl/vats_scale.sv =====
// Output stage: scale the harmonic sum by 0.49 and round to a signed Q2.15 sample.
`timescale 1ns / 1ps
module vats_scale (
  input  logic                                  clk,
  input  logic                                  rst,
  input  vats_pkg::link_t                       link_in,
  output logic                                  done,
  output logic signed [vats_pkg::SAMPLE_W-1:0]  sample
);

  logic signed [51:0] scaled;
  logic signed [51:0] p1;
  logic               v1;
  logic signed [51:0] rounded;

  assign scaled = 52'(link_in.acc) * 52'(vats_pkg::SCALE_Q16);

  always_ff @(posedge clk) begin
    p1 <= scaled;
    if (rst) v1 <= 1'b0;
    else v1 <= link_in.valid;
  end

  assign rounded = p1 + 52'sd2147483648;

  always_ff @(posedge clk) begin
    sample <= rounded[48:32];
    if (rst) done <= 1'b0;
    else done <= v1;
  end

endmodule

// ===== tb/sv/violin_additive_tone_sample_tb.sv =====
// Testbench for violin_additive_tone_sample: directed and random tones against a local predictor.
`timescale 1ns / 1ps
module violin_additive_tone_sample_tb;

  localparam int RANDOM_TONES = 1530;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_GAP = 11;

  localparam int WAVE_DEPTH = 1024;
  localparam int PHASE_BITS = 16;
  localparam int QTR = WAVE_DEPTH / 4;
  localparam longint unsigned PHASE_MASK = (64'd1 << PHASE_BITS) - 1;
  localparam longint unsigned QUARTER_TURN = 64'd1 << (PHASE_BITS - 2);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint GAIN_Q16 = 32113;

  localparam int PARTIALS = 8;
  localparam int unsigned PARTIAL_N [PARTIALS] = '{1, 2, 3, 4, 6, 7, 8, 10};
  localparam bit PARTIAL_COS [PARTIALS] = '{0, 1, 0, 1, 1, 0, 1, 1};
  localparam longint PARTIAL_AMP [PARTIALS] =
    '{65208, 61604, 27853, 31457, 23921, 2621, 5571, 5898};

  localparam logic [22:0] FREQ_MAX = '1;
  localparam logic [31:0] TIME_MAX = '1;
  localparam logic [22:0] ONE_HZ = 23'd256;
  localparam logic [31:0] ONE_SEC = 32'd1 << 24;

  typedef struct packed {
    logic [22:0] freq;
    logic [31:0] tim;
  } tone_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [22:0] fundamental_freq = '0;
  logic [31:0] time_index = '0;
  logic done;
  logic signed [16:0] sample;

  logic [15:0] sine_quarter [0:QTR];
  tone_req_t tone_reqs[$];
  logic signed [16:0] sample_fifo[$];
  logic signed [16:0] want;
  logic xfer_seen = 1'b0;
  int wait_left = 0;
  int burst_left = 0;
  int accepted = 0;
  int total_tones = 0;
  int fault_count = 0;
  int idle_cycles = 0;

  violin_additive_tone_sample dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .fundamental_freq(fundamental_freq),
    .time_index(time_index),
    .done(done),
    .sample(sample)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Q1.15 quarter-wave entry from a Q2.30 Taylor series
  function automatic logic [15:0] quarter_sine(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint acc;
    longint v;
    x = (longint'(k) * HALF_PI_Q30 + QTR / 2) / QTR;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1)
        acc = acc - longint'(term);
      else
        acc = acc + longint'(term);
    end
    if (acc < 0)
      acc = 0;
    v = (acc + 16384) >>> 15;
    if (v > 32767)
      v = 32767;
    return 16'(v);
  endfunction

  function automatic logic signed [16:0] violin_sample_of(input logic [22:0] f,
                                                          input logic [31:0] t);
    longint unsigned prod;
    longint unsigned ph;
    int idx;
    int quad;
    int off;
    longint mag;
    longint acc;
    longint scaled;
    prod = 64'(f) * 64'(t);
    acc = 0;
    for (int h = 0; h < PARTIALS; h++) begin
      ph = ((prod * PARTIAL_N[h]) >> (32 - PHASE_BITS)) & PHASE_MASK;
      if (PARTIAL_COS[h])
        ph = (ph + QUARTER_TURN) & PHASE_MASK;
      idx = int'((ph * WAVE_DEPTH) >> PHASE_BITS);
      quad = (idx / QTR) % 4;
      off = idx % QTR;
      if (quad % 2 == 1)
        off = QTR - off;
      mag = longint'(sine_quarter[off]);
      if (quad >= 2)
        mag = -mag;
      acc = acc + mag * PARTIAL_AMP[h];
    end
    scaled = (acc * GAIN_Q16 + (64'sd1 <<< 31)) >>> 32;
    return 17'(scaled);
  endfunction

  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left = burst_left - 1;
      return 0;
    end
    if ($urandom_range(0, 39) == 0)
      burst_left = $urandom_range(20, 60);
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic report_fault(input string what, input logic signed [16:0] exp_v,
                              input logic signed [16:0] got_v);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s: expected sample %0d, got %0d", $realtime, what, exp_v, got_v);
  endtask

  task automatic add_tone(input logic [22:0] f, input logic [31:0] t);
    tone_req_t r;
    r.freq = f;
    r.tim = t;
    tone_reqs.push_back(r);
    total_tones++;
  endtask

  // driver
  always @(negedge clk) begin
    tone_req_t r;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !xfer_seen) begin
      start <= 1'b1;
    end else if (wait_left > 0) begin
      start <= 1'b0;
      wait_left <= wait_left - 1;
    end else if (tone_reqs.size() > 0) begin
      r = tone_reqs.pop_front();
      fundamental_freq <= r.freq;
      time_index <= r.tim;
      start <= 1'b1;
      wait_left <= draw_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    xfer_seen <= start && !busy;
    if (!rst) begin
      if (start && !busy) begin
        sample_fifo.push_back(violin_sample_of(fundamental_freq, time_index));
        accepted++;
      end
      if (done) begin
        if (sample_fifo.size() == 0) begin
          report_fault("unexpected transaction", 'x, sample);
        end else begin
          want = sample_fifo.pop_front();
          if (sample !== want)
            report_fault("sample mismatch", want, sample);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [22:0] f;
    logic [31:0] t;
    int mode;
    for (int k = 0; k <= QTR; k++)
      sine_quarter[k] = quarter_sine(k);

    add_tone('0, '0);
    add_tone(FREQ_MAX, '0);
    add_tone('0, TIME_MAX);
    add_tone(FREQ_MAX, TIME_MAX);
    add_tone(23'd1, 32'd1);
    add_tone(ONE_HZ, ONE_SEC);
    add_tone(ONE_HZ, ONE_SEC >> 2);
    add_tone(ONE_HZ, ONE_SEC >> 1);
    add_tone(ONE_HZ, (ONE_SEC >> 2) * 3);
    add_tone(ONE_HZ, (ONE_SEC >> 2) - 32'd64);
    add_tone(23'd1, 32'hFFFF0000);
    add_tone(23'd1, 32'h0000FFFF);
    add_tone(23'd1, 32'h00010000);
    add_tone(23'h555555, 32'hAAAAAAAA);
    add_tone(23'h2AAAAA, 32'h55555555);
    add_tone(23'd112640, ONE_SEC / 1000);
    add_tone(23'd112640, 32'd12345);
    add_tone(23'd5120, 32'd777777);
    add_tone(FREQ_MAX, 32'd1);
    add_tone(23'd1, TIME_MAX);

    for (int i = 0; i < RANDOM_TONES; i++) begin
      mode = $urandom_range(0, 7);
      f = 23'($urandom());
      t = $urandom();
      if (mode < 2)
        f = 23'($urandom_range(20 * 256, 20000 * 256));
      else if (mode == 2)
        t = $urandom_range(0, 32'h0FFFFFFF);
      else if (mode == 3)
        f = 23'($urandom_range(0, 255));
      add_tone(f, t);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted < total_tones)
      @(posedge clk);
    while (sample_fifo.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sample_fifo.size() > 0)
      fault_count++;
    if (fault_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
